// ===== sv/wmvd_pkg.sv =====
`default_nettype none

package wmvd_pkg;

  localparam int WINDOW     = 16;
  localparam int WIN_LOG    = $clog2(WINDOW);
  localparam int PTR_W      = WIN_LOG;
  localparam int SAMPLE_W   = 16;
  localparam int SUM_W      = SAMPLE_W + WIN_LOG;
  // a squared sample is at most 2^30, so 31 bits unsigned
  localparam int SQ_ITEM_W  = 2 * SAMPLE_W - 1;
  localparam int SQ_W       = SQ_ITEM_W + WIN_LOG;
  localparam int VAR_W      = 32;
  localparam int CMP_W      = VAR_W + 2 * WIN_LOG;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_MEAN_THRESHOLD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_VARIANCE_LIMIT = CFG_IDX_W'(1);

  localparam logic [SAMPLE_W-1:0] MEAN_THRESHOLD_RST = SAMPLE_W'(13107);
  localparam logic [VAR_W-1:0]    VARIANCE_LIMIT_RST = VAR_W'(2684355);

  // window totals after one word has gone into the ring
  typedef struct packed {
    logic                    full;
    logic signed [SUM_W-1:0] sum;
    logic [SQ_W-1:0]         sq;
  } wmvd_acc_t;

  // stage load enables from the handshake control
  typedef struct packed {
    logic ld_test;
    logic ld_out;
  } wmvd_adv_t;

endpackage

`default_nettype wire

// ===== sv/windowed_mean_variance_detector_core.sv =====
// channel   dir  handshake            word
// -------   ---  -------------------  -------------------------------
// in        in   in_valid / in_stall  sample (16b signed Q2.14)
// out       out  out_valid / out_stall converged, window_full
// cfg       in   cfg_valid / cfg_ready cfg_index (8b), cfg_data (32b)
//
// One word per clock while the output is not stalled; a result passes through
// three register stages after its sample is taken (ring and running sums, square of
// the sum, variance compare).
// rst is synchronous: pointer, sums, full flag and valids clear, registers
// return to their defaults. The ring contents need no clear.
// A stalled output holds; the two internal stages keep taking words until full.
`default_nettype none

module windowed_mean_variance_detector_core (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic signed [wmvd_pkg::SAMPLE_W-1:0]  sample,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic                                       converged,
  output logic                                       window_full,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [wmvd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [wmvd_pkg::CFG_DATA_W-1:0]       cfg_data
);

  logic [wmvd_pkg::SAMPLE_W-1:0] mean_threshold;
  logic [wmvd_pkg::VAR_W-1:0]    variance_limit;

  logic                 acc_valid;
  logic                 test_valid;
  logic                 take;
  logic                 out_ready;
  logic                 test_ready;
  logic                 acc_ready;
  wmvd_pkg::wmvd_adv_t  adv;
  wmvd_pkg::wmvd_acc_t  acc;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mean_threshold <= wmvd_pkg::MEAN_THRESHOLD_RST;
      variance_limit <= wmvd_pkg::VARIANCE_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == wmvd_pkg::REG_MEAN_THRESHOLD) begin
        mean_threshold <= cfg_data[wmvd_pkg::SAMPLE_W-1:0];
      end else if (cfg_index == wmvd_pkg::REG_VARIANCE_LIMIT) begin
        variance_limit <= cfg_data[wmvd_pkg::VAR_W-1:0];
      end
    end
  end

  // each stage loads when it is empty or its word moves on
  assign out_ready   = !out_valid || !out_stall;
  assign adv.ld_out  = test_valid && out_ready;
  assign test_ready  = !test_valid || out_ready;
  assign adv.ld_test = acc_valid && test_ready;
  assign acc_ready   = !acc_valid || test_ready;
  assign in_stall    = !acc_ready;
  assign take        = in_valid && acc_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_valid  <= 1'b0;
      test_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (take) begin
        acc_valid <= 1'b1;
      end else if (adv.ld_test) begin
        acc_valid <= 1'b0;
      end
      if (adv.ld_test) begin
        test_valid <= 1'b1;
      end else if (adv.ld_out) begin
        test_valid <= 1'b0;
      end
      if (adv.ld_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  wmvd_window u_window (
    .clk    (clk),
    .rst    (rst),
    .take   (take),
    .sample (sample),
    .acc    (acc)
  );

  wmvd_test u_test (
    .clk            (clk),
    .acc            (acc),
    .adv            (adv),
    .mean_threshold (mean_threshold),
    .variance_limit (variance_limit),
    .converged      (converged),
    .window_full    (window_full)
  );

endmodule

`default_nettype wire

// ===== sv/wmvd_window.sv =====
`default_nettype none

module wmvd_window (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  take,
  input  wire logic signed [wmvd_pkg::SAMPLE_W-1:0]  sample,
  output wmvd_pkg::wmvd_acc_t                        acc
);

  localparam int SUM_EXT = wmvd_pkg::SUM_W - wmvd_pkg::SAMPLE_W;

  logic [wmvd_pkg::SAMPLE_W-1:0]     store [wmvd_pkg::WINDOW];
  logic [wmvd_pkg::PTR_W-1:0]        ptr;
  logic [wmvd_pkg::PTR_W-1:0]        ptr_next;
  logic                              full;
  logic                              full_next;
  logic signed [wmvd_pkg::SUM_W-1:0] sum;
  logic signed [wmvd_pkg::SUM_W-1:0] sum_next;
  logic [wmvd_pkg::SQ_W-1:0]         sq;
  logic [wmvd_pkg::SQ_W-1:0]         sq_next;

  logic signed [wmvd_pkg::SAMPLE_W-1:0]   old_val;
  logic signed [2*wmvd_pkg::SAMPLE_W-1:0] new_sq;
  logic signed [2*wmvd_pkg::SAMPLE_W-1:0] old_sq;
  logic                                   wrap;

  // entries are only read again after the first wrap, so the store needs no clear
  assign old_val = full ? $signed(store[ptr]) : '0;
  assign new_sq  = sample * sample;
  assign old_sq  = old_val * old_val;
  assign wrap    = (ptr == wmvd_pkg::PTR_W'(wmvd_pkg::WINDOW - 1));

  assign ptr_next  = wrap ? '0 : ptr + wmvd_pkg::PTR_W'(1);
  assign full_next = full | wrap;
  assign sum_next  = sum + $signed({{SUM_EXT{sample[wmvd_pkg::SAMPLE_W-1]}}, sample})
                         - $signed({{SUM_EXT{old_val[wmvd_pkg::SAMPLE_W-1]}}, old_val});
  assign sq_next   = sq + {{wmvd_pkg::WIN_LOG{1'b0}}, new_sq[wmvd_pkg::SQ_ITEM_W-1:0]}
                        - {{wmvd_pkg::WIN_LOG{1'b0}}, old_sq[wmvd_pkg::SQ_ITEM_W-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr  <= '0;
      full <= 1'b0;
      sum  <= '0;
      sq   <= '0;
    end else if (take) begin
      ptr  <= ptr_next;
      full <= full_next;
      sum  <= sum_next;
      sq   <= sq_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      store[ptr] <= sample;
      acc.full   <= full_next;
      acc.sum    <= sum_next;
      acc.sq     <= sq_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/wmvd_test.sv =====
`default_nettype none

module wmvd_test (
  input  wire logic                                 clk,
  input  wire wmvd_pkg::wmvd_acc_t                  acc,
  input  wire wmvd_pkg::wmvd_adv_t                  adv,
  input  wire logic [wmvd_pkg::SAMPLE_W-1:0]        mean_threshold,
  input  wire logic [wmvd_pkg::VAR_W-1:0]           variance_limit,
  output logic                                      converged,
  output logic                                      window_full
);

  localparam int SUM_EXT = wmvd_pkg::SUM_W - wmvd_pkg::SAMPLE_W;

  logic signed [wmvd_pkg::SUM_W-1:0]   mean_bound;
  logic signed [2*wmvd_pkg::SUM_W-1:0] sum_sq;
  logic [wmvd_pkg::CMP_W-1:0]          n_sq;
  logic [wmvd_pkg::CMP_W-1:0]          var_bound;
  logic [wmvd_pkg::CMP_W-1:0]          spread;

  logic                                t_full;
  logic                                t_mean_ok;
  logic [wmvd_pkg::CMP_W-1:0]          t_n_sq;
  logic [wmvd_pkg::CMP_W-1:0]          t_sum_sq;

  // mean test: S >= threshold * N
  assign mean_bound = $signed({{SUM_EXT{mean_threshold[wmvd_pkg::SAMPLE_W-1]}},
                               mean_threshold})
                      * $signed(wmvd_pkg::SUM_W'(wmvd_pkg::WINDOW));
  assign sum_sq     = acc.sum * acc.sum;
  assign n_sq       = wmvd_pkg::CMP_W'(acc.sq) * wmvd_pkg::CMP_W'(wmvd_pkg::WINDOW);

  // variance test: N*Q - S*S < limit * N^2, never negative on the left
  assign var_bound  = wmvd_pkg::CMP_W'(variance_limit)
                      * wmvd_pkg::CMP_W'(wmvd_pkg::WINDOW * wmvd_pkg::WINDOW);
  assign spread     = t_n_sq - t_sum_sq;

  always_ff @(posedge clk) begin
    if (adv.ld_test) begin
      t_full    <= acc.full;
      t_mean_ok <= (acc.sum >= mean_bound);
      t_n_sq    <= n_sq;
      t_sum_sq  <= wmvd_pkg::CMP_W'(sum_sq);
    end
  end

  always_ff @(posedge clk) begin
    if (adv.ld_out) begin
      converged   <= t_full & t_mean_ok & (spread < var_bound);
      window_full <= t_full;
    end
  end

endmodule

`default_nettype wire

// ===== sv/wmvd_checker.sv =====
`default_nettype none

module wmvd_checker (
  input wire logic                                  clk,
  input wire logic                                  rst,
  input wire logic                                  in_valid,
  input wire logic                                  in_stall,
  input wire logic                                  out_valid,
  input wire logic                                  out_stall,
  input wire logic                                  converged,
  input wire logic                                  window_full
);

  logic                        in_acc;
  logic                        out_acc;
  logic [2:0]                  pending;
  logic [wmvd_pkg::PTR_W:0]    delivered;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= '0;
      delivered <= '0;
    end else begin
      pending <= pending + 3'(in_acc) - 3'(out_acc);
      if (out_acc && (delivered != (wmvd_pkg::PTR_W + 1)'(wmvd_pkg::WINDOW))) begin
        delivered <= delivered + (wmvd_pkg::PTR_W + 1)'(1);
      end
    end
  end

  // no result without a word taken in before it
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 3'd0)
    else $error("result without a pending word");

  a_conv_needs_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && converged |-> window_full)
    else $error("converged before window full");

  // full flag rises exactly with the WINDOW-th result and stays
  a_full_timing: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (window_full ==
                   (delivered >= (wmvd_pkg::PTR_W + 1)'(wmvd_pkg::WINDOW - 1))))
    else $error("window_full at wrong result");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(converged) && $stable(window_full))
    else $error("stalled result changed");

endmodule

bind windowed_mean_variance_detector_core wmvd_checker u_wmvd_checker (.*);

`default_nettype wire
